// File: rtl/core/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator and mapper.
// No dependencies.
package bpa_pkg;

    localparam int POOL_PAGES_DEF = 16384;
    localparam int PAGE_SHIFT     = 12;
    localparam int WORD_BITS      = 32;
    localparam int DIR_WORDS      = 32;
    localparam int DIR_KERN_WORD  = 24;
    localparam int MAX_RUN        = 64;
    localparam logic [2:0] ENTRY_FLAGS = 3'b111;

    localparam logic [31:0] RST_KERNEL_PHYS_BASE = 32'h0020_0000;
    localparam logic [31:0] RST_USER_PHYS_BASE   = 32'h0110_0000;
    localparam logic [14:0] RST_KERNEL_PAGES     = 15'd3840;
    localparam logic [14:0] RST_USER_PAGES       = 15'd3840;
    localparam logic [31:0] RST_KERNEL_VIRT_BASE = 32'hc010_0000;
    localparam logic [31:0] RST_USER_VIRT_BASE   = 32'h0804_8000;
    localparam logic [14:0] RST_USER_VIRT_PAGES  = 15'd3840;

    typedef enum logic [2:0] {
        CFG_KERNEL_PHYS_BASE = 3'd0,
        CFG_USER_PHYS_BASE   = 3'd1,
        CFG_KERNEL_PAGES     = 3'd2,
        CFG_USER_PAGES       = 3'd3,
        CFG_KERNEL_VIRT_BASE = 3'd4,
        CFG_USER_VIRT_BASE   = 3'd5,
        CFG_USER_VIRT_PAGES  = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_MAPPED   = 2'd0,
        ST_NO_VIRT  = 2'd1,
        ST_NO_PHYS  = 2'd2,
        ST_OUTSIDE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] kernel_phys_base;
        logic [31:0] user_phys_base;
        logic [14:0] kernel_pages;
        logic [14:0] user_pages;
        logic [31:0] kernel_virt_base;
        logic [31:0] user_virt_base;
        logic [14:0] user_virt_pages;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic        pool_select;
        logic [6:0]  page_count;
        logic [31:0] fixed_vaddr;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
        logic [31:0] entry_word;
        logic        table_page_new;
        logic [31:0] table_page_addr;
        logic        last;
    } res_t;

endpackage

// File: rtl/core/bpa_engine.sv
// Allocation engine: bitmap memories, directory memory and request sequencer.
// Depends on bpa_pkg.
module bpa_engine #(
    parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bpa_pkg::cfg_t cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  bpa_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output bpa_pkg::res_t res
);
    import bpa_pkg::*;

    localparam int POOL_WORDS = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int PW         = $clog2(POOL_WORDS * WORD_BITS);
    localparam int PAW        = PW - 5;
    localparam int WW         = PAW + 1;
    localparam int SW         = PW + 1;
    localparam int CW         = (SW > 15) ? SW : 15;
    localparam int CLR_WORDS  = (POOL_WORDS > DIR_WORDS) ? POOL_WORDS : DIR_WORDS;
    localparam int CLW        = $clog2(CLR_WORDS);

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_FIX_RD   = 14'b00000000000100,
        S_FIX_WR   = 14'b00000000001000,
        S_SCAN_RD  = 14'b00000000010000,
        S_SCAN_BIT = 14'b00000000100000,
        S_MARK_RD  = 14'b00000001000000,
        S_MARK_WR  = 14'b00000010000000,
        S_PHYS_RD  = 14'b00000100000000,
        S_PHYS_CHK = 14'b00001000000000,
        S_DIR_RD   = 14'b00010000000000,
        S_DIR_CHK  = 14'b00100000000000,
        S_DIR_SET  = 14'b01000000000000,
        S_RESULT   = 14'b10000000000000
    } state_t;

    logic [31:0] vk_mem [POOL_WORDS];
    logic [31:0] vu_mem [POOL_WORDS];
    logic [31:0] pk_mem [POOL_WORDS];
    logic [31:0] pu_mem [POOL_WORDS];
    logic [31:0] dir_mem [DIR_WORDS];

    state_t      state_reg, state_next;
    logic [CLW-1:0] clr_reg, clr_next;
    logic        kern_reg, kern_next;
    logic        tbl_reg, tbl_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  k_reg, k_next;
    logic [6:0]  run_reg, run_next;
    logic [WW-1:0] w_reg, w_next;
    logic [4:0]  b_reg, b_next;
    logic [PW-1:0] start_reg, start_next;
    logic [PW-1:0] end_reg, end_next;
    status_t     st_reg, st_next;
    logic [31:0] va_reg, va_next;
    logic [31:0] pa_reg, pa_next;
    logic [31:0] ew_reg, ew_next;
    logic        tn_reg, tn_next;
    logic [31:0] ta_reg, ta_next;
    logic        last_reg, last_next;
    logic [31:0] vq_reg, pq_reg, dq_reg;

    logic          v_re, v_we, p_re, p_we, d_re, d_we;
    logic [PAW-1:0] v_addr, p_addr;
    logic [4:0]    d_addr;
    logic [31:0]   v_wdata, p_wdata, d_wdata;
    logic          clearing, clr_pool, clr_dir;

    logic          kern_sel, psel_k;
    logic [31:0]   vbase, pbase;
    logic [SW-1:0] vsize, psize;
    logic [31:0]   fdiff;
    logic [SW-1:0] scan_idx;
    logic [31:0]   mark_mask, free_mask;
    logic          free_any;
    logic [4:0]    free_bit;
    logic [PW-1:0] free_page;
    logic [31:0]   free_addr;
    logic          fail_free;

    function automatic logic [SW-1:0] clamp(input logic [14:0] n);
        logic [CW-1:0] e;
        e = CW'(n);
        if (e > CW'(POOL_WORDS * WORD_BITS) || e > CW'(POOL_PAGES))
        begin
            e = CW'(POOL_PAGES);
        end
        return SW'(e);
    endfunction

    assign clearing = (state_reg == S_CLEAR);
    assign clr_pool = clearing && (CW'(clr_reg) < CW'(POOL_WORDS));
    assign clr_dir  = clearing && (CW'(clr_reg) < CW'(DIR_WORDS));

    assign kern_sel = (state_reg == S_IDLE) ? req.pool_select : kern_reg;
    assign psel_k   = tbl_reg || kern_reg;
    assign vbase    = kern_sel ? cfg.kernel_virt_base : cfg.user_virt_base;
    assign vsize    = kern_sel ? clamp(cfg.kernel_pages) : clamp(cfg.user_virt_pages);
    assign pbase    = psel_k ? cfg.kernel_phys_base : cfg.user_phys_base;
    assign psize    = psel_k ? clamp(cfg.kernel_pages) : clamp(cfg.user_pages);
    assign fdiff    = req.fixed_vaddr - vbase;
    assign scan_idx = {w_reg, b_reg};

    always_comb
    begin
        logic [PW-1:0] pg;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            pg = {w_reg[PAW-1:0], 5'(j)};
            mark_mask[j] = (pg >= start_reg) && (pg <= end_reg);
            free_mask[j] = !pq_reg[j] && (SW'({w_reg, 5'(j)}) < psize);
        end
    end

    always_comb
    begin
        free_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (free_mask[j])
            begin
                free_bit = 5'(j);
            end
        end
    end

    assign free_any  = |free_mask;
    assign free_page = {w_reg[PAW-1:0], free_bit};
    assign free_addr = pbase + 32'({free_page, {PAGE_SHIFT{1'b0}}});
    assign fail_free = (SW'({w_reg, 5'b0}) >= psize);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        kern_next  = kern_reg;
        tbl_next   = tbl_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        run_next   = run_reg;
        w_next     = w_reg;
        b_next     = b_reg;
        start_next = start_reg;
        end_next   = end_reg;
        st_next    = st_reg;
        va_next    = va_reg;
        pa_next    = pa_reg;
        ew_next    = ew_reg;
        tn_next    = tn_reg;
        ta_next    = ta_reg;
        last_next  = last_reg;
        v_re = 1'b0; v_we = 1'b0; p_re = 1'b0; p_we = 1'b0; d_re = 1'b0; d_we = 1'b0;
        v_addr  = clr_reg[PAW-1:0];
        p_addr  = clr_reg[PAW-1:0];
        d_addr  = clr_reg[4:0];
        v_wdata = '0;
        p_wdata = '0;
        d_wdata = (CW'(clr_reg) >= CW'(DIR_KERN_WORD)) ? '1 : '0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (CW'(clr_reg) == CW'(CLR_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kern_next = req.pool_select;
                    cnt_next  = req.action ? 7'd1 : req.page_count;
                    k_next    = '0;
                    tbl_next  = 1'b0;
                    tn_next   = 1'b0;
                    ta_next   = '0;
                    pa_next   = '0;
                    ew_next   = '0;
                    last_next = 1'b1;
                    if (req.action)
                    begin
                        va_next = req.fixed_vaddr;
                        if (req.fixed_vaddr < vbase || fdiff[31:PAGE_SHIFT] >= 20'(vsize))
                        begin
                            st_next    = ST_OUTSIDE;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            start_next = fdiff[PAGE_SHIFT +: PW];
                            state_next = S_FIX_RD;
                        end
                    end
                    else
                    begin
                        va_next = '0;
                        if (req.page_count == 7'd0 || req.page_count > 7'(MAX_RUN))
                        begin
                            st_next    = ST_NO_VIRT;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            w_next     = '0;
                            run_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                end
            end
            S_FIX_RD:
            begin
                v_re       = 1'b1;
                v_addr     = start_reg[PW-1:5];
                state_next = S_FIX_WR;
            end
            S_FIX_WR:
            begin
                v_we       = 1'b1;
                v_addr     = start_reg[PW-1:5];
                v_wdata    = vq_reg | (32'd1 << start_reg[4:0]);
                w_next     = '0;
                state_next = S_PHYS_RD;
            end
            S_SCAN_RD:
            begin
                if (SW'({w_reg, 5'b0}) >= vsize)
                begin
                    st_next    = ST_NO_VIRT;
                    state_next = S_RESULT;
                end
                else
                begin
                    v_re       = 1'b1;
                    v_addr     = w_reg[PAW-1:0];
                    b_next     = '0;
                    state_next = S_SCAN_BIT;
                end
            end
            S_SCAN_BIT:
            begin
                if (scan_idx >= vsize)
                begin
                    st_next    = ST_NO_VIRT;
                    state_next = S_RESULT;
                end
                else if (vq_reg[b_reg])
                begin
                    run_next = '0;
                end
                else
                begin
                    run_next = run_reg + 1'b1;
                end
                if (scan_idx < vsize)
                begin
                    if (!vq_reg[b_reg] && (run_reg + 1'b1) == cnt_reg)
                    begin
                        start_next = scan_idx[PW-1:0] + PW'(1) - PW'(cnt_reg);
                        end_next   = scan_idx[PW-1:0];
                        w_next     = WW'(start_next[PW-1:5]);
                        state_next = S_MARK_RD;
                    end
                    else if (b_reg == 5'd31)
                    begin
                        w_next     = w_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        b_next = b_reg + 1'b1;
                    end
                end
            end
            S_MARK_RD:
            begin
                v_re       = 1'b1;
                v_addr     = w_reg[PAW-1:0];
                state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                v_we    = 1'b1;
                v_addr  = w_reg[PAW-1:0];
                v_wdata = vq_reg | mark_mask;
                if (w_reg[PAW-1:0] == end_reg[PW-1:5])
                begin
                    va_next    = vbase + 32'({start_reg, {PAGE_SHIFT{1'b0}}});
                    w_next     = '0;
                    state_next = S_PHYS_RD;
                end
                else
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_MARK_RD;
                end
            end
            S_PHYS_RD:
            begin
                if (fail_free)
                begin
                    st_next    = ST_NO_PHYS;
                    last_next  = 1'b1;
                    tn_next    = 1'b0;
                    ta_next    = '0;
                    if (!tbl_reg)
                    begin
                        pa_next = '0;
                        ew_next = '0;
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    p_re       = 1'b1;
                    p_addr     = w_reg[PAW-1:0];
                    state_next = S_PHYS_CHK;
                end
            end
            S_PHYS_CHK:
            begin
                if (free_any)
                begin
                    p_we    = 1'b1;
                    p_addr  = w_reg[PAW-1:0];
                    p_wdata = pq_reg | (32'd1 << free_bit);
                    if (tbl_reg)
                    begin
                        ta_next    = free_addr;
                        tn_next    = 1'b1;
                        state_next = S_DIR_SET;
                    end
                    else
                    begin
                        pa_next    = free_addr;
                        ew_next    = {free_addr[31:3], free_addr[2:0] | ENTRY_FLAGS};
                        state_next = S_DIR_RD;
                    end
                end
                else
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_PHYS_RD;
                end
            end
            S_DIR_RD:
            begin
                d_re       = 1'b1;
                d_addr     = va_reg[31:27];
                state_next = S_DIR_CHK;
            end
            S_DIR_CHK:
            begin
                if (dq_reg[va_reg[26:22]])
                begin
                    st_next    = ST_MAPPED;
                    last_next  = (k_reg + 1'b1) == cnt_reg;
                    state_next = S_RESULT;
                end
                else
                begin
                    tbl_next   = 1'b1;
                    w_next     = '0;
                    state_next = S_PHYS_RD;
                end
            end
            S_DIR_SET:
            begin
                d_we       = 1'b1;
                d_addr     = va_reg[31:27];
                d_wdata    = dq_reg | (32'd1 << va_reg[26:22]);
                st_next    = ST_MAPPED;
                last_next  = (k_reg + 1'b1) == cnt_reg;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        va_next    = va_reg + (32'd1 << PAGE_SHIFT);
                        w_next     = '0;
                        tbl_next   = 1'b0;
                        tn_next    = 1'b0;
                        ta_next    = '0;
                        state_next = S_PHYS_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kern_reg  <= kern_next;
        tbl_reg   <= tbl_next;
        cnt_reg   <= cnt_next;
        k_reg     <= k_next;
        run_reg   <= run_next;
        w_reg     <= w_next;
        b_reg     <= b_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        st_reg    <= st_next;
        va_reg    <= va_next;
        pa_reg    <= pa_next;
        ew_reg    <= ew_next;
        tn_reg    <= tn_next;
        ta_reg    <= ta_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (clr_pool || (v_we && kern_reg))
        begin
            vk_mem[v_addr] <= v_wdata;
        end
        if (clr_pool || (v_we && !kern_reg))
        begin
            vu_mem[v_addr] <= v_wdata;
        end
        if (v_re)
        begin
            vq_reg <= kern_reg ? vk_mem[v_addr] : vu_mem[v_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_pool || (p_we && psel_k))
        begin
            pk_mem[p_addr] <= p_wdata;
        end
        if (clr_pool || (p_we && !psel_k))
        begin
            pu_mem[p_addr] <= p_wdata;
        end
        if (p_re)
        begin
            pq_reg <= psel_k ? pk_mem[p_addr] : pu_mem[p_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_dir || d_we)
        begin
            dir_mem[d_addr] <= d_wdata;
        end
        if (d_re)
        begin
            dq_reg <= dir_mem[d_addr];
        end
    end

    assign req_ready           = (state_reg == S_IDLE);
    assign res_valid           = (state_reg == S_RESULT);
    assign res.status          = st_reg;
    assign res.virt_addr       = va_reg;
    assign res.phys_addr       = pa_reg;
    assign res.entry_word      = ew_reg;
    assign res.table_page_new  = tn_reg;
    assign res.table_page_addr = ta_reg;
    assign res.last            = last_reg;

endmodule

// File: rtl/core/bitmap_page_allocator_mapper_top.sv
// After reset a clearing pass over the bitmap and directory memories holds s_tready low.
// A run request scans the virtual bitmap bit by bit within each 32-page word, then marks
// the run with a read and a write per word; each page searches the physical bitmap word
// by word and then looks up the directory; a new table page adds a search of the kernel
// physical bitmap and a directory write to set the entry.
// Throughput: one request at a time; the next is taken once its last item is handed to
// the output register. Reset returns the sequencer to the clearing pass, which clears all
// bitmaps and reloads the directory with only the kernel entries present.
module bitmap_page_allocator_mapper_top #(
    parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // action, pool_select, page_count[7], fixed_vaddr[32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // status[2], virt_addr, phys_addr, entry_word,
                                    // table_page_new, table_page_addr
    output logic         m_tlast
);
    import bpa_pkg::*;

    cfg_t cfg_reg;
    req_t req;
    res_t res;
    res_t out_reg;
    logic out_valid_reg;
    logic res_valid, res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_phys_base <= RST_KERNEL_PHYS_BASE;
            cfg_reg.user_phys_base   <= RST_USER_PHYS_BASE;
            cfg_reg.kernel_pages     <= RST_KERNEL_PAGES;
            cfg_reg.user_pages       <= RST_USER_PAGES;
            cfg_reg.kernel_virt_base <= RST_KERNEL_VIRT_BASE;
            cfg_reg.user_virt_base   <= RST_USER_VIRT_BASE;
            cfg_reg.user_virt_pages  <= RST_USER_VIRT_PAGES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KERNEL_PHYS_BASE: cfg_reg.kernel_phys_base <= cfg_data;
                CFG_USER_PHYS_BASE:   cfg_reg.user_phys_base   <= cfg_data;
                CFG_KERNEL_PAGES:     cfg_reg.kernel_pages     <= cfg_data[14:0];
                CFG_USER_PAGES:       cfg_reg.user_pages       <= cfg_data[14:0];
                CFG_KERNEL_VIRT_BASE: cfg_reg.kernel_virt_base <= cfg_data;
                CFG_USER_VIRT_BASE:   cfg_reg.user_virt_base   <= cfg_data;
                CFG_USER_VIRT_PAGES:  cfg_reg.user_virt_pages  <= cfg_data[14:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign req.action      = s_tdata[0];
    assign req.pool_select = s_tdata[1];
    assign req.page_count  = s_tdata[8:2];
    assign req.fixed_vaddr = s_tdata[40:9];

    bpa_engine #(
        .POOL_PAGES (POOL_PAGES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'b0, out_reg.table_page_addr, out_reg.table_page_new,
                       out_reg.entry_word, out_reg.phys_addr, out_reg.virt_addr,
                       out_reg.status};

endmodule

// File: rtl/core/bpa_checker.sv
// Port-level checks of the bitmap page allocator and mapper, bound to the top level.
// Depends on bitmap_page_allocator_mapper_top.
module bpa_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tlast)
        else $error("failure item does not end the request");

    a_entry_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == 2'd0 |->
            m_tdata[97:69] == m_tdata[65:37] && m_tdata[68:66] == 3'b111)
        else $error("entry word does not match frame address");

    a_table_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[98] |-> m_tdata[130:99] == 32'd0)
        else $error("table address without new table page");

endmodule

bind bitmap_page_allocator_mapper_top bpa_checker u_bpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
